// File: rtl/core/bgi_pkg.sv
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared types and codes of the bilinear grid interpolator.
// ----------------------------------------------------------------------------
package bgi_pkg;

    // fixed field widths
    localparam int LP_FUNC_W   = 2;
    localparam int LP_INDEX_W  = 4;
    localparam int LP_DATA_W   = 32;
    localparam int LP_COUNT_W  = 5;
    localparam int LP_STATUS_W = 2;

    // defaults and fixed arithmetic range
    localparam int LP_MAX_BREAKS = 16;
    localparam int LP_VALUE_WIDTH = 32;
    localparam logic [LP_COUNT_W-1:0] LP_COUNT_RESET = LP_COUNT_W'(16);

    // item functions
    localparam logic [LP_FUNC_W-1:0] FN_GRID  = 2'd0;
    localparam logic [LP_FUNC_W-1:0] FN_XBRK  = 2'd1;
    localparam logic [LP_FUNC_W-1:0] FN_YBRK  = 2'd2;
    localparam logic [LP_FUNC_W-1:0] FN_QUERY = 2'd3;

    // result status
    localparam logic [LP_STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [LP_STATUS_W-1:0] ST_OUTSIDE   = 2'd1;
    localparam logic [LP_STATUS_W-1:0] ST_ZERO_AREA = 2'd2;
    localparam logic [LP_STATUS_W-1:0] ST_SAT       = 2'd3;

    // configuration register indexes
    localparam logic CFG_X_COUNT = 1'b0;
    localparam logic CFG_Y_COUNT = 1'b1;

    // one queued item
    typedef struct packed {
        logic [LP_FUNC_W-1:0]         func;
        logic [LP_INDEX_W-1:0]        row_index;
        logic [LP_INDEX_W-1:0]        col_index;
        logic signed [LP_DATA_W-1:0]  write_value;
        logic signed [LP_DATA_W-1:0]  query_x;
        logic signed [LP_DATA_W-1:0]  query_y;
    } t_item;

endpackage

// File: rtl/core/bgi_front.sv
// ----------------------------------------------------------------------------
// bgi_front
// Accepts items, drops writes whose index is out of range and queues the
// rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bgi_front import bgi_pkg::*; #(
    parameter int MAX_BREAKS = LP_MAX_BREAKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [LP_FUNC_W-1:0]          i_func,
    input  logic [LP_INDEX_W-1:0]         i_row_index,
    input  logic [LP_INDEX_W-1:0]         i_col_index,
    input  logic signed [LP_DATA_W-1:0]   i_write_value,
    input  logic signed [LP_DATA_W-1:0]   i_query_x,
    input  logic signed [LP_DATA_W-1:0]   i_query_y,
    output logic                          o_q_valid,
    output t_item                         o_q_item,
    input  logic                          i_q_pop
);

    localparam int QDEPTH = 2;

    t_item       r_mem [QDEPTH];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        w_keep;
    logic        w_push;
    t_item       w_item;

    // classify: writes beyond the store are dropped
    always_comb begin
        case (i_func)
            FN_GRID:  w_keep = (int'(i_row_index) < MAX_BREAKS) &&
                               (int'(i_col_index) < MAX_BREAKS);
            FN_XBRK:  w_keep = int'(i_col_index) < MAX_BREAKS;
            FN_YBRK:  w_keep = int'(i_row_index) < MAX_BREAKS;
            default:  w_keep = 1'b1;
        endcase
    end

    assign w_item.func        = i_func;
    assign w_item.row_index   = i_row_index;
    assign w_item.col_index   = i_col_index;
    assign w_item.write_value = i_write_value;
    assign w_item.query_x     = i_query_x;
    assign w_item.query_y     = i_query_y;

    assign o_stall   = (r_cnt == 2'(QDEPTH));
    assign w_push    = i_valid && !o_stall && w_keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_item;
    end

endmodule

// File: rtl/core/bgi_back.sv
// ----------------------------------------------------------------------------
// bgi_back
// Carries out queued items: store writes, and queries through a breakpoint
// scan, corner fetch, shared multipliers and a two-bit-per-cycle divider.
// ----------------------------------------------------------------------------
module bgi_back import bgi_pkg::*; #(
    parameter int MAX_BREAKS = LP_MAX_BREAKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  t_item                         i_q_item,
    output logic                          o_q_pop,
    input  logic [LP_COUNT_W-1:0]         i_x_count,
    input  logic [LP_COUNT_W-1:0]         i_y_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [LP_DATA_W-1:0]   o_interp_value,
    output logic [LP_STATUS_W-1:0]        o_status
);

    localparam int IW = $clog2(MAX_BREAKS);
    localparam int CW = $clog2(MAX_BREAKS + 1);
    localparam int GW = $clog2(MAX_BREAKS * MAX_BREAKS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_SCANW = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_GRID  = 4'd4;
    localparam logic [3:0] S_GRIDW = 4'd5;
    localparam logic [3:0] S_AREA  = 4'd6;
    localparam logic [3:0] S_MULA  = 4'd7;
    localparam logic [3:0] S_MULB  = 4'd8;
    localparam logic [3:0] S_MULC  = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_NEG   = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_ROUND = 4'd13;
    localparam logic [3:0] S_SAT   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    function automatic logic [CW-1:0] clamp_cnt(input logic [LP_COUNT_W-1:0] c);
        int v;
        v = int'(c);
        if (v < 2) v = 2;
        else if (v > MAX_BREAKS) v = MAX_BREAKS;
        return CW'(v);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [32:0] sx(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    // stores
    logic signed [31:0] r_xmem [MAX_BREAKS];
    logic signed [31:0] r_ymem [MAX_BREAKS];
    logic signed [31:0] r_gmem [MAX_BREAKS * MAX_BREAKS];

    // control
    logic [3:0]          r_state;
    logic                r_ov;
    logic                r_dv;
    logic                r_gv;

    // scan
    logic [CW-1:0]       r_k;
    logic [CW-1:0]       r_kd;
    logic [CW-1:0]       r_nx;
    logic [CW-1:0]       r_ny;
    logic [CW-1:0]       w_nmax;
    logic signed [31:0]  r_xd;
    logic signed [31:0]  r_yd;
    logic signed [31:0]  r_qx;
    logic signed [31:0]  r_qy;
    logic signed [31:0]  r_xlo;
    logic signed [31:0]  r_xhi;
    logic signed [31:0]  r_ylo;
    logic signed [31:0]  r_yhi;
    logic [IW-1:0]       r_c1;
    logic [IW-1:0]       r_r1;
    logic signed [31:0]  r_x1;
    logic signed [31:0]  r_x2;
    logic signed [31:0]  r_y1;
    logic signed [31:0]  r_y2;

    // corners and products
    logic [1:0]          r_j;
    logic [1:0]          r_jd;
    logic signed [31:0]  r_gd;
    logic signed [31:0]  r_g [4];
    logic [GW-1:0]       w_graddr;
    logic [IW-1:0]       w_grow;
    logic [IW-1:0]       w_gcol;
    logic signed [32:0]  r_dxa;
    logic signed [32:0]  r_dxb;
    logic signed [32:0]  r_dya;
    logic signed [32:0]  r_dyb;
    logic signed [32:0]  r_wx;
    logic signed [32:0]  r_wy;
    logic signed [32:0]  w_sa;
    logic signed [32:0]  w_sb;
    logic [65:0]         w_pa;
    logic [63:0]         w_pb;
    logic [63:0]         r_m;
    logic [31:0]         r_qm;
    logic                r_tneg;
    logic [63:0]         r_pl;
    logic [63:0]         r_ph;
    logic [95:0]         w_tmag;
    logic [127:0]        w_term;
    logic [127:0]        r_acc;
    logic [63:0]         r_area;
    logic                r_aneg;
    logic                r_nneg;

    // divider
    logic [127:0]        r_num;
    logic [63:0]         r_rem;
    logic [5:0]          r_dc;
    logic [63:0]         d_t1;
    logic [63:0]         d_r1;
    logic                d_b1;
    logic [63:0]         d_t2;
    logic [63:0]         d_r2;
    logic                d_b2;

    // result
    logic                w_outside;
    logic                w_zero;
    logic                w_sneg;
    logic [127:0]        w_lim;
    logic [63:0]         w_ql;
    logic [63:0]         w_res64;
    logic                w_sat;
    logic signed [31:0]  r_res;
    logic [1:0]          r_stat;
    logic signed [31:0]  r_oval;
    logic [1:0]          r_ostat;

    assign o_q_pop        = (r_state == S_IDLE) && i_q_valid;
    assign o_valid        = r_ov;
    assign o_interp_value = r_oval;
    assign o_status       = r_ostat;

    assign w_nmax = (r_nx > r_ny) ? r_nx : r_ny;

    // range and cell checks
    assign w_outside = (r_qx < r_xlo) || (r_qx > r_xhi) || (r_qy < r_ylo) || (r_qy > r_yhi);
    assign w_zero    = (r_x2 == r_x1) || (r_y2 == r_y1);

    // corner address
    assign w_grow   = r_r1 + IW'(r_j[1]);
    assign w_gcol   = r_c1 + IW'(r_j[0]);
    assign w_graddr = GW'(int'(w_grow) * MAX_BREAKS + int'(w_gcol));

    // distance multiplier, also used for the cell area
    always_comb begin
        if (r_state == S_AREA) begin
            w_sa = r_wx;
            w_sb = r_wy;
        end else begin
            w_sa = r_j[0] ? r_dxb : r_dxa;
            w_sb = r_j[1] ? r_dyb : r_dya;
        end
    end
    assign w_pa = 66'(mag33(w_sa)) * 66'(mag33(w_sb));

    // corner value times product, one 32-bit half at a time
    assign w_pb = 64'(r_qm) * 64'((r_state == S_MULB) ? r_m[31:0] : r_m[63:32]);

    assign w_tmag = 96'(r_pl) + {r_ph, 32'd0};
    assign w_term = r_tneg ? (128'd0 - 128'(w_tmag)) : 128'(w_tmag);

    // two restoring division steps per cycle
    always_comb begin
        d_t1 = {r_rem[62:0], r_num[127]};
        d_b1 = r_rem[63] || (d_t1 >= r_area);
        d_r1 = d_b1 ? (d_t1 - r_area) : d_t1;
        d_t2 = {d_r1[62:0], r_num[126]};
        d_b2 = d_r1[63] || (d_t2 >= r_area);
        d_r2 = d_b2 ? (d_t2 - r_area) : d_t2;
    end

    // saturation of the rounded quotient
    always_comb begin
        w_sneg = r_nneg ^ r_aneg;
        w_lim  = (128'd1 << (LP_VALUE_WIDTH - 1)) - (w_sneg ? 128'd0 : 128'd1);
        w_sat  = r_num > w_lim;
        w_ql   = w_sat ? w_lim[63:0] : r_num[63:0];
        w_res64 = w_sneg ? (64'd0 - w_ql) : w_ql;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_dv    <= 1'b0;
            r_gv    <= 1'b0;
        end else begin
            r_dv <= (r_state == S_SCAN);
            r_gv <= (r_state == S_GRID);
            if (r_state == S_OUT && (!r_ov || !i_stall)) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE:  begin
                    if (i_q_valid && i_q_item.func == FN_QUERY) r_state <= S_SCAN;
                end
                S_SCAN:  begin
                    if (int'(r_k) == int'(w_nmax) - 1) r_state <= S_SCANW;
                end
                S_SCANW: r_state <= S_CHECK;
                S_CHECK: r_state <= (w_outside || w_zero) ? S_OUT : S_GRID;
                S_GRID:  begin
                    if (r_j == 2'd3) r_state <= S_GRIDW;
                end
                S_GRIDW: r_state <= S_AREA;
                S_AREA:  r_state <= S_MULA;
                S_MULA:  r_state <= S_MULB;
                S_MULB:  r_state <= S_MULC;
                S_MULC:  r_state <= S_ACC;
                S_ACC:   r_state <= (r_j == 2'd3) ? S_NEG : S_MULA;
                S_NEG:   r_state <= S_DIV;
                S_DIV:   begin
                    if (r_dc == 6'd63) r_state <= S_ROUND;
                end
                S_ROUND: r_state <= S_SAT;
                S_SAT:   r_state <= S_OUT;
                S_OUT:   begin
                    if (!r_ov || !i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            case (i_q_item.func)
                FN_GRID: r_gmem[GW'(int'(i_q_item.row_index) * MAX_BREAKS +
                                    int'(i_q_item.col_index))] <= i_q_item.write_value;
                FN_XBRK: r_xmem[IW'(i_q_item.col_index)] <= i_q_item.write_value;
                FN_YBRK: r_ymem[IW'(i_q_item.row_index)] <= i_q_item.write_value;
                default: ;
            endcase
        end
        r_xd <= r_xmem[r_k[IW-1:0]];
        r_yd <= r_ymem[r_k[IW-1:0]];
        r_gd <= r_gmem[w_graddr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_kd <= r_k;
        r_jd <= r_j;

        // breakpoint scan, one entry of each axis per cycle
        if (r_dv) begin
            if (r_kd == '0) begin
                r_xlo <= r_xd;
                r_x1  <= r_xd;
            end
            if (int'(r_kd) == int'(r_nx) - 1) r_xhi <= r_xd;
            if (r_kd != '0 && int'(r_kd) <= int'(r_nx) - 2 && r_xd <= r_qx) begin
                r_c1 <= IW'(r_kd);
                r_x1 <= r_xd;
            end
            if (r_kd != '0 && int'(r_kd) <= int'(r_nx) - 1 &&
                int'(r_kd) - 1 == int'(r_c1)) r_x2 <= r_xd;

            if (r_kd == '0) begin
                r_ylo <= r_yd;
                r_y1  <= r_yd;
            end
            if (int'(r_kd) == int'(r_ny) - 1) r_yhi <= r_yd;
            if (r_kd != '0 && int'(r_kd) <= int'(r_ny) - 2 && r_yd <= r_qy) begin
                r_r1 <= IW'(r_kd);
                r_y1 <= r_yd;
            end
            if (r_kd != '0 && int'(r_kd) <= int'(r_ny) - 1 &&
                int'(r_kd) - 1 == int'(r_r1)) r_y2 <= r_yd;
        end

        // corner capture
        if (r_gv) r_g[r_jd] <= r_gd;

        case (r_state)
            S_IDLE:  begin
                r_qx <= i_q_item.query_x;
                r_qy <= i_q_item.query_y;
                r_nx <= clamp_cnt(i_x_count);
                r_ny <= clamp_cnt(i_y_count);
                r_k  <= '0;
                r_c1 <= '0;
                r_r1 <= '0;
            end
            S_SCAN:  r_k <= r_k + CW'(1);
            S_CHECK: begin
                r_j    <= 2'd0;
                r_res  <= '0;
                r_stat <= w_outside ? ST_OUTSIDE : ST_ZERO_AREA;
                r_dxa  <= sx(r_x2) - sx(r_qx);
                r_dxb  <= sx(r_qx) - sx(r_x1);
                r_dya  <= sx(r_y2) - sx(r_qy);
                r_dyb  <= sx(r_qy) - sx(r_y1);
                r_wx   <= sx(r_x2) - sx(r_x1);
                r_wy   <= sx(r_y2) - sx(r_y1);
            end
            S_GRID:  r_j <= r_j + 2'd1;
            S_AREA:  begin
                r_area <= w_pa[63:0];
                r_aneg <= r_wx[32] ^ r_wy[32];
                r_acc  <= '0;
            end
            S_MULA:  begin
                r_m    <= w_pa[63:0];
                r_qm   <= r_g[r_j][31] ? 32'(-r_g[r_j]) : 32'(r_g[r_j]);
                r_tneg <= r_g[r_j][31] ^ w_sa[32] ^ w_sb[32];
            end
            S_MULB:  r_pl <= w_pb;
            S_MULC:  r_ph <= w_pb;
            S_ACC:   begin
                r_acc <= r_acc + w_term;
                r_j   <= r_j + 2'd1;
            end
            S_NEG:   begin
                r_nneg <= r_acc[127];
                r_num  <= r_acc[127] ? (128'd0 - r_acc) : r_acc;
                r_rem  <= '0;
                r_dc   <= '0;
            end
            S_DIV:   begin
                r_num <= {r_num[125:0], d_b1, d_b2};
                r_rem <= d_r2;
                r_dc  <= r_dc + 6'd1;
            end
            S_ROUND: r_num <= r_num + 128'(r_rem >= (r_area - r_rem));
            S_SAT:   begin
                r_res  <= w_res64[31:0];
                r_stat <= w_sat ? ST_SAT : ST_OK;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ov || !i_stall)) begin
            r_oval  <= r_res;
            r_ostat <= r_stat;
        end
    end

`ifndef SYNTHESIS
    a_zero_when_not_computed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_ostat == ST_OUTSIDE || r_ostat == ST_ZERO_AREA)) |-> (r_oval == '0))
        else $error("outside or zero-area result carries a nonzero value");

    a_div_exits_to_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_ROUND))
        else $error("divider left early");

    a_out_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ov && i_stall) |=> (r_state == S_OUT && r_ov))
        else $error("result overwritten while output stalled");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_q_pop)
        else $error("queue popped during a query");
`endif

endmodule

// File: rtl/core/bilinear_grid_interpolator.sv
// timing: a write waits in the queue until the back end pops it while idle; a query inside
//   the breaks runs the scan (one break per cycle, up to the larger clamped count), the corner
//   fetch, products and divider (two quotient bits per cycle); outside or zero-area ends after the check
// throughput: one write per cycle while the back end is idle; a query holds the back end until its result is registered
// reset: synchronous active low; counts return to 16, stores are not cleared
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator
// Bilinear interpolation over a grid with non-uniform breakpoints. The front
// queues items, the back runs writes and queries; counts live here.
// ----------------------------------------------------------------------------
module bilinear_grid_interpolator import bgi_pkg::*; #(
    parameter int MAX_BREAKS = LP_MAX_BREAKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [LP_COUNT_W-1:0]         i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [LP_FUNC_W-1:0]          i_func,
    input  logic [LP_INDEX_W-1:0]         i_row_index,
    input  logic [LP_INDEX_W-1:0]         i_col_index,
    input  logic signed [LP_DATA_W-1:0]   i_write_value,
    input  logic signed [LP_DATA_W-1:0]   i_query_x,
    input  logic signed [LP_DATA_W-1:0]   i_query_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [LP_DATA_W-1:0]   o_interp_value,
    output logic [LP_STATUS_W-1:0]        o_status
);

    logic [LP_COUNT_W-1:0] r_x_count;
    logic [LP_COUNT_W-1:0] r_y_count;
    logic                  w_q_valid;
    t_item                 w_q_item;
    logic                  w_q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_count <= LP_COUNT_RESET;
            r_y_count <= LP_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_X_COUNT: r_x_count <= i_cfg_wdata;
                CFG_Y_COUNT: r_y_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // item intake and queue
    bgi_front #(.MAX_BREAKS(MAX_BREAKS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .i_query_x     (i_query_x),
        .i_query_y     (i_query_y),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    // execution
    bgi_back #(.MAX_BREAKS(MAX_BREAKS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_q_pop),
        .i_x_count      (r_x_count),
        .i_y_count      (r_y_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_interp_value (o_interp_value),
        .o_status       (o_status)
    );

endmodule
